>>> rtl/core/icf_pkg.sv
// ----------------------------------------------------------------------------
// icf_pkg
// Shared types, constants and helpers of the IMU complementary filter.
// ----------------------------------------------------------------------------
package icf_pkg;

  localparam logic [16:0] AlphaOne    = 17'd65536;
  localparam logic [16:0] AlphaReset  = 17'd64225;
  // 180/pi in Q7.24
  localparam logic [30:0] DegPerRadQ24 = 31'd961263669;
  localparam int unsigned MaxSteps    = 32;

  typedef enum logic [1:0] {
    CFG_ALPHA    = 2'd0,
    CFG_GYRO_DB  = 2'd1,
    CFG_ACCEL_DB = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic               done;
    logic signed [27:0] angle;   // Q3.24 rad
  } lane_res_t;

  // arctan(2^-i) in Q0.24 radians
  function automatic logic [23:0] atan_q24(input logic [4:0] i);
    logic [23:0] r;
    case (i)
      5'd0:  r = 24'd13176795;
      5'd1:  r = 24'd7778716;
      5'd2:  r = 24'd4110060;
      5'd3:  r = 24'd2086331;
      5'd4:  r = 24'd1047214;
      5'd5:  r = 24'd524117;
      5'd6:  r = 24'd262123;
      5'd7:  r = 24'd131069;
      5'd8:  r = 24'd65536;
      5'd9:  r = 24'd32768;
      5'd10: r = 24'd16384;
      5'd11: r = 24'd8192;
      5'd12: r = 24'd4096;
      5'd13: r = 24'd2048;
      5'd14: r = 24'd1024;
      5'd15: r = 24'd512;
      5'd16: r = 24'd256;
      5'd17: r = 24'd128;
      5'd18: r = 24'd64;
      5'd19: r = 24'd32;
      5'd20: r = 24'd16;
      5'd21: r = 24'd8;
      5'd22: r = 24'd4;
      5'd23: r = 24'd2;
      5'd24: r = 24'd1;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > 52'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -52'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // zero a reading whose magnitude is below the band
  function automatic logic signed [15:0] dead16(input logic signed [15:0] v,
                                                input logic [14:0] band);
    logic [16:0] m;
    m = v[15] ? 17'(-$signed({v[15], v})) : {1'b0, v};
    return (m < {2'b00, band}) ? 16'sd0 : v;
  endfunction

endpackage

>>> rtl/core/icf_tilt_lane.sv
// ----------------------------------------------------------------------------
// icf_tilt_lane
// One tilt lane: digit-by-digit square root, then vectoring CORDIC atan2.
// ----------------------------------------------------------------------------
module icf_tilt_lane import icf_pkg::*; #(
  parameter int unsigned STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [16:0] num_i,
  input  logic signed [15:0] a_i,
  input  logic signed [15:0] b_i,
  output lane_res_t          res_o
);

  localparam int unsigned NSteps = (STEPS > MaxSteps) ? MaxSteps : STEPS;
  localparam int unsigned CntW   = $clog2(NSteps + 1);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_SQRT = 3'b010,
    L_CORD = 3'b100
  } lane_state_e;

  lane_state_e        state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               done_q, done_d;
  logic               zero_q;
  logic signed [16:0] num_q;
  logic [31:0]        n_q, n_d, res_q, res_d, bit_q, bit_d;
  logic signed [39:0] x_q, x_d, y_q, y_d;
  logic signed [27:0] z_q, z_d;
  logic signed [31:0] asq, bsq;
  logic [32:0]        trial;
  logic [4:0]         idx;
  logic signed [39:0] dx, dy;
  logic signed [27:0] at;

  assign asq   = a_i * a_i;
  assign bsq   = b_i * b_i;
  assign trial = {1'b0, res_q} + {1'b0, bit_q};
  assign idx   = 5'(cnt_q);
  assign dx    = y_q >>> idx;
  assign dy    = x_q >>> idx;
  assign at    = $signed({4'b0000, atan_q24(idx)});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    n_d     = n_q;
    res_d   = res_q;
    bit_d   = bit_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          n_d     = 32'(asq) + 32'(bsq);
          res_d   = '0;
          bit_d   = 32'h4000_0000;
          cnt_d   = '0;
          z_d     = '0;
          state_d = L_SQRT;
        end
      end
      L_SQRT: begin
        if ({1'b0, n_q} >= trial) begin
          n_d   = n_q - trial[31:0];
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(15)) begin
          x_d     = $signed({4'b0000, res_d[15:0], 20'b0});
          y_d     = $signed({{3{num_q[16]}}, num_q, 20'b0});
          cnt_d   = '0;
          state_d = L_CORD;
        end
      end
      L_CORD: begin
        if (y_q > 40'sd0) begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + at;
        end else begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - at;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(NSteps - 1)) begin
          done_d  = 1'b1;
          state_d = L_IDLE;
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == L_IDLE && start_i) begin
      num_q  <= num_i;
      zero_q <= (num_i == 17'sd0);
    end
    n_q   <= n_d;
    res_q <= res_d;
    bit_q <= bit_d;
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
  end

  // atan2 of a zero numerator is exactly zero
  assign res_o.done  = done_q;
  assign res_o.angle = zero_q ? 28'sd0 : z_q;

endmodule

>>> rtl/core/icf_merge.sv
// ----------------------------------------------------------------------------
// icf_merge
// Gyro integration, complementary blend, angle state and degree conversion.
// ----------------------------------------------------------------------------
module icf_merge import icf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               clear_i,
  input  logic               take_i,
  input  logic signed [15:0] gp_i,
  input  logic signed [15:0] gr_i,
  input  logic signed [15:0] gy_i,
  input  logic [19:0]        ts_i,
  input  logic [16:0]        alpha_i,
  input  logic signed [27:0] pitch_acc_i,
  input  logic signed [27:0] roll_acc_i,
  output logic               done_o,
  output logic [30:0]        pitch_deg_o,
  output logic [30:0]        roll_deg_o,
  output logic [30:0]        yaw_deg_o
);

  typedef enum logic [5:0] {
    M_IDLE  = 6'b000001,
    M_MUL   = 6'b000010,
    M_BLEND = 6'b000100,
    M_SUM   = 6'b001000,
    M_DEG   = 6'b010000,
    M_OUT   = 6'b100000
  } merge_state_e;

  merge_state_e       state_q;
  logic signed [31:0] ang_q [3];
  logic signed [36:0] gprod_q [3];
  logic signed [50:0] pa_q [2];
  logic signed [45:0] pb_q [2];
  logic signed [62:0] dprod_q [3];
  logic signed [28:0] d [3];
  logic signed [32:0] sa [3];
  logic signed [27:0] acc [2];
  logic signed [51:0] bsum [2];
  logic signed [63:0] dround [3];
  logic signed [31:0] dv [3];
  logic [30:0]        deg [3];
  logic [16:0]        alpha_c, beta;
  logic signed [20:0] ts_s;

  assign ts_s    = $signed({1'b0, ts_i});
  assign alpha_c = (alpha_i > AlphaOne) ? AlphaOne : alpha_i;
  assign beta    = AlphaOne - alpha_c;
  assign acc[0]  = pitch_acc_i;
  assign acc[1]  = roll_acc_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d[k]  = 29'((gprod_q[k] + 37'sd128) >>> 8);
      sa[k] = $signed({ang_q[k][31], ang_q[k]}) + $signed({{4{d[k][28]}}, d[k]});
      dround[k] = ($signed({dprod_q[k][62], dprod_q[k]}) + 64'sd2147483648) >>> 32;
      dv[k] = dround[k][31:0];
      if (dv[k] > 32'sd1073741823) begin
        deg[k] = 31'h3FFFFFFF;
      end else if (dv[k] < -32'sd1073741824) begin
        deg[k] = 31'h40000000;
      end else begin
        deg[k] = dv[k][30:0];
      end
    end
    for (int k = 0; k < 2; k++) begin
      bsum[k] = ($signed({pa_q[k][50], pa_q[k]}) + 52'(pb_q[k]) + 52'sd32768) >>> 16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      for (int k = 0; k < 3; k++) begin
        ang_q[k] <= '0;
      end
    end else begin
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            if (clear_i) begin
              for (int k = 0; k < 3; k++) begin
                ang_q[k] <= '0;
              end
              state_q <= M_DEG;
            end else begin
              state_q <= M_MUL;
            end
          end
        end
        M_MUL:   state_q <= M_BLEND;
        M_BLEND: begin
          ang_q[2] <= sat32(52'(sa[2]));
          state_q  <= M_SUM;
        end
        M_SUM: begin
          ang_q[0] <= sat32(bsum[0]);
          ang_q[1] <= sat32(bsum[1]);
          state_q  <= M_DEG;
        end
        M_DEG:   state_q <= M_OUT;
        M_OUT: begin
          if (take_i) begin
            state_q <= M_IDLE;
          end
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == M_MUL) begin
      gprod_q[0] <= gp_i * ts_s;
      gprod_q[1] <= gr_i * ts_s;
      gprod_q[2] <= gy_i * ts_s;
    end
    if (state_q == M_BLEND) begin
      for (int k = 0; k < 2; k++) begin
        pa_q[k] <= $signed({1'b0, alpha_c}) * sa[k];
        pb_q[k] <= $signed({1'b0, beta}) * acc[k];
      end
    end
    if (state_q == M_DEG) begin
      for (int k = 0; k < 3; k++) begin
        dprod_q[k] <= ang_q[k] * $signed({1'b0, DegPerRadQ24});
      end
    end
  end

  assign done_o      = (state_q == M_OUT) && take_i;
  assign pitch_deg_o = deg[0];
  assign roll_deg_o  = deg[1];
  assign yaw_deg_o   = deg[2];

endmodule

>>> rtl/core/imu_complementary_filter.sv
// ----------------------------------------------------------------------------
// imu_complementary_filter
// Six-axis complementary-filter attitude estimator with two tilt lanes.
// ----------------------------------------------------------------------------
// A sample runs through the square root and the CORDIC (one step a cycle)
// in the pitch and roll lanes side by side, followed by blending and degree
// conversion. A clear word zeroes the angle state and goes straight to
// degree conversion. One sample is in flight at a time; a finished result
// waits in the output register while the next word is accepted.
module imu_complementary_filter import icf_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [16:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // accel_pitch_axis, accel_roll_axis, accel_yaw_axis, gyro_pitch_rate,
  // gyro_roll_rate, gyro_yaw_rate, sample_period, 4 pad bits
  input  logic [119:0] s_axis_tdata,
  // op
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pitch_deg, roll_deg, yaw_deg, 3 pad bits
  output logic [95:0]  m_axis_tdata
);

  typedef enum logic [2:0] {
    T_IDLE  = 3'b001,
    T_TILT  = 3'b010,
    T_MERGE = 3'b100
  } top_state_e;

  top_state_e         state_q;
  logic [16:0]        alpha_q;
  logic [14:0]        gyro_db_q, accel_db_q;
  logic signed [15:0] gp_q, gr_q, gy_q;
  logic [19:0]        ts_q;
  logic signed [15:0] ap, ar, ay;
  logic               in_acc, mg_start, mg_done, take;
  lane_res_t          pitch_res, roll_res;
  logic [30:0]        pitch_deg, roll_deg, yaw_deg;
  logic               m_valid_q;
  logic [95:0]        m_data_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == T_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign ap = dead16($signed(s_axis_tdata[15:0]), accel_db_q);
  assign ar = dead16($signed(s_axis_tdata[31:16]), accel_db_q);
  assign ay = dead16($signed(s_axis_tdata[47:32]), accel_db_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= AlphaReset;
      gyro_db_q  <= '0;
      accel_db_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ALPHA:    alpha_q    <= cfg_data_i;
        CFG_GYRO_DB:  gyro_db_q  <= cfg_data_i[14:0];
        CFG_ACCEL_DB: accel_db_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      gp_q <= dead16($signed(s_axis_tdata[63:48]), gyro_db_q);
      gr_q <= dead16($signed(s_axis_tdata[79:64]), gyro_db_q);
      gy_q <= dead16($signed(s_axis_tdata[95:80]), gyro_db_q);
      ts_q <= s_axis_tdata[115:96];
    end
  end

  icf_tilt_lane #(.STEPS(CORDIC_STEPS)) u_pitch_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && !s_axis_tuser),
    .num_i   (17'(-$signed({ar[15], ar}))),
    .a_i     (ay),
    .b_i     (ap),
    .res_o   (pitch_res)
  );

  icf_tilt_lane #(.STEPS(CORDIC_STEPS)) u_roll_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && !s_axis_tuser),
    .num_i   ($signed({ap[15], ap})),
    .a_i     (ay),
    .b_i     (ar),
    .res_o   (roll_res)
  );

  assign mg_start = (in_acc && s_axis_tuser) || (state_q == T_TILT && pitch_res.done);
  assign take     = !m_valid_q || m_axis_tready;

  icf_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (mg_start),
    .clear_i     (s_axis_tuser && in_acc),
    .take_i      (take),
    .gp_i        (gp_q),
    .gr_i        (gr_q),
    .gy_i        (gy_q),
    .ts_i        (ts_q),
    .alpha_i     (alpha_q),
    .pitch_acc_i (pitch_res.angle),
    .roll_acc_i  (roll_res.angle),
    .done_o      (mg_done),
    .pitch_deg_o (pitch_deg),
    .roll_deg_o  (roll_deg),
    .yaw_deg_o   (yaw_deg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= T_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      case (state_q)
        T_IDLE: begin
          if (in_acc) begin
            state_q <= s_axis_tuser ? T_MERGE : T_TILT;
          end
        end
        T_TILT: begin
          if (pitch_res.done) begin
            state_q <= T_MERGE;
          end
        end
        T_MERGE: begin
          if (mg_done) begin
            state_q <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
      if (mg_done) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mg_done) begin
      m_data_q <= {3'b000, yaw_deg, roll_deg, pitch_deg};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef ASSERT_OFF
  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pitch_res.done == roll_res.done)
    else $error("tilt lanes finished out of step");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input ready while a sample is in flight");

  a_merge_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mg_done |-> (!m_valid_q || m_axis_tready))
    else $error("result written over a word not yet taken");

  a_lane_done_in_tilt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pitch_res.done |-> (state_q == T_TILT))
    else $error("lane result outside tilt phase");
`endif

endmodule

>>> test/tb_imu_complementary_filter.sv
// ----------------------------------------------------------------------------
// tb_imu_complementary_filter
// Self-checking bench for the complementary filter: a directed table, then
// random samples under random source and sink stalls, all results compared
// against a fixed-point attitude predictor kept in lock step.
// ----------------------------------------------------------------------------
module tb_imu_complementary_filter import icf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 20000;

  typedef struct {
    logic               op;
    logic signed [15:0] ap, ar, ay, gp, gr, gy;
    logic [19:0]        ts;
  } sample_t;

  typedef struct {
    logic signed [30:0] pitch, roll, yaw;
  } attitude_t;

  typedef struct {
    sample_t s;
    logic    known;
    attitude_t a;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [16:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;

  imu_complementary_filter i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  longint unsigned alpha_q, gyro_band, accel_band;
  longint pitch_q, roll_q, yaw_q;
  attitude_t pending_att[$];
  int errors = 0;
  int words_in = 0, results_seen = 0, clears_sent = 0;
  int idle_cycles = 0;
  logic stim_done = 1'b0;

  const longint AtanTab[32] = '{13176795, 7778716, 4110060, 2086331, 1047214,
    524117, 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint deadband(longint v, longint unsigned band);
    longint m;
    m = v < 0 ? -v : v;
    return (m < longint'(band)) ? 0 : v;
  endfunction

  function automatic longint floor_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint tilt_angle(longint num, longint a, longint b);
    longint x, y, z, dx, dy;
    if (num == 0) return 0;
    x = floor_root(longint'(a * a + b * b)) * 1048576;
    y = num * 1048576;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += AtanTab[i];
      end else begin
        x -= dx; y += dy; z -= AtanTab[i];
      end
    end
    return z;
  endfunction

  function automatic longint mix(longint ang, longint d, longint acc, longint al);
    return clip32((al * (ang + d) + (65536 - al) * acc + 32768) >>> 16);
  endfunction

  function automatic logic signed [30:0] to_degrees(longint ang);
    return 31'((ang * 961263669 + 64'sd2147483648) >>> 32);
  endfunction

  function automatic attitude_t filter_step(sample_t s);
    longint ap, ar, ay, gp, gr, gy, ts, al, pa, ra;
    attitude_t r;
    if (s.op) begin
      pitch_q = 0; roll_q = 0; yaw_q = 0;
    end else begin
      ap = deadband(s.ap, accel_band);
      ar = deadband(s.ar, accel_band);
      ay = deadband(s.ay, accel_band);
      gp = deadband(s.gp, gyro_band);
      gr = deadband(s.gr, gyro_band);
      gy = deadband(s.gy, gyro_band);
      ts = longint'(s.ts);
      al = alpha_q > 65536 ? 65536 : longint'(alpha_q);
      pa = tilt_angle(-ar, ay, ap);
      ra = tilt_angle(ap, ay, ar);
      pitch_q = mix(pitch_q, (gp * ts + 128) >>> 8, pa, al);
      roll_q = mix(roll_q, (gr * ts + 128) >>> 8, ra, al);
      yaw_q = clip32(yaw_q + ((gy * ts + 128) >>> 8));
    end
    r.pitch = to_degrees(pitch_q);
    r.roll = to_degrees(roll_q);
    r.yaw = to_degrees(yaw_q);
    return r;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [16:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ALPHA:    alpha_q = val;
      CFG_GYRO_DB:  gyro_band = val[14:0];
      CFG_ACCEL_DB: accel_band = val[14:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // push one word; compare against a typed-in value when the row has one
  task automatic send_sample(sample_t s, logic known = 1'b0, attitude_t a = '{0, 0, 0});
    attitude_t e;
    int gap;
    gap = $urandom_range(0, 14);
    // move off the falling edge that dropped the previous word
    repeat ((gap == 0) ? 1 : gap) @(negedge clk_i);
    s_axis_tdata <= {4'b0, s.ts, s.gy, s.gr, s.gp, s.ay, s.ar, s.ap};
    s_axis_tuser <= s.op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    e = filter_step(s);
    if (known && e != a) begin
      $error("table row disagrees with predictor: pitch %0d roll %0d yaw %0d",
             a.pitch, a.roll, a.yaw);
      errors++;
    end
    pending_att.push_back(e);
    words_in++;
    if (s.op) clears_sent++;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_att.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rnd_axis();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t rnd_sample();
    sample_t s;
    s.op = ($urandom_range(0, 29) == 0);
    s.ap = rnd_axis(); s.ar = rnd_axis(); s.ay = rnd_axis();
    s.gp = rnd_axis(); s.gr = rnd_axis(); s.gy = rnd_axis();
    s.ts = ($urandom_range(0, 7) == 0) ? 20'($urandom) : 20'($urandom_range(0, 2048));
    return s;
  endfunction

  // result sink with random stalls
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
  end

  always @(posedge clk_i) begin
    attitude_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_att.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = pending_att.pop_front();
        if (m_axis_tdata[30:0] !== e.pitch) begin
          $error("pitch_deg expected %0d got %0d", e.pitch, $signed(m_axis_tdata[30:0]));
          errors++;
        end
        if (m_axis_tdata[61:31] !== e.roll) begin
          $error("roll_deg expected %0d got %0d", e.roll, $signed(m_axis_tdata[61:31]));
          errors++;
        end
        if (m_axis_tdata[92:62] !== e.yaw) begin
          $error("yaw_deg expected %0d got %0d", e.yaw, $signed(m_axis_tdata[92:62]));
          errors++;
        end
      end
    end
  end

  // watchdog on accepted words
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni || stim_done ||
        (!s_axis_tvalid && !cfg_valid_i && pending_att.size() == 0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    row_t tbl[$];
    row_t r;
    attitude_t z;
    logic [16:0] alphas[5];
    z = '{0, 0, 0};
    alpha_q = 64225; gyro_band = 0; accel_band = 0;
    pitch_q = 0; roll_q = 0; yaw_q = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table: zero vector, extremes, zero denominator, clear
    tbl.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0}, 1, z});
    tbl.push_back('{'{1, 0, 0, 0, 0, 0, 0, 0}, 1, z});
    tbl.push_back('{'{0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                      16'sh7FFF, 20'hFFFFF}, 0, z});
    tbl.push_back('{'{0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                      16'sh8000, 20'hFFFFF}, 0, z});
    tbl.push_back('{'{0, 0, 100, 0, 0, 0, 0, 0}, 0, z});
    tbl.push_back('{'{0, 100, 0, 0, 0, 0, 0, 0}, 0, z});
    tbl.push_back('{'{0, 16'sh8000, 16'sh7FFF, 0, 0, 0, 0, 1}, 0, z});
    tbl.push_back('{'{1, 16'sh7FFF, 5, 5, 5, 5, 5, 5}, 1, z});
    tbl.push_back('{'{0, 0, 0, 16384, 4096, -4096, 4096, 1024}, 0, z});
    tbl.push_back('{'{0, -3, 7, 16384, 16'sh7FFF, 16'sh8000, 0, 20'hFFFFF}, 0, z});
    for (int i = 0; i < 6; i++)
      tbl.push_back('{'{0, 16'(i * 40 - 90), 16'(7 - i * 3), 16'(16000 - i), 16'(i * 900),
                        16'(-i * 700), 16'(i * 1234), 20'(i * 50000)}, 0, z});
    tbl.push_back('{'{1, 0, 0, 0, 0, 0, 0, 0}, 1, z});
    foreach (tbl[i]) send_sample(tbl[i].s, tbl[i].known, tbl[i].a);

    // hold off until every result is back
    drain();
    write_reg(CFG_ALPHA, 17'd65536);
    write_reg(CFG_GYRO_DB, 17'd100);
    write_reg(CFG_ACCEL_DB, 17'd50);
    for (int i = 0; i < 6; i++) begin
      r.s = rnd_sample();
      send_sample(r.s);
    end
    drain();
    write_reg(CFG_ALPHA, 17'h1FFFF);
    write_reg(CFG_GYRO_DB, 17'h7FFF);
    write_reg(CFG_ACCEL_DB, 17'h7FFF);
    send_sample('{0, 16'sh7FFF, 16'sh8000, 16'sh7FFE, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 20'hFFFFF});
    send_sample('{0, 16'sh8001, 1, 16'sh7FFF, 16'sh8001, 9, 16'sh8000, 20'h80000});

    alphas = '{17'd0, 17'd65536, 17'd64225, 17'd32768, 17'd60000};
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(CFG_ALPHA, alphas[ph]);
      write_reg(CFG_GYRO_DB, (ph % 2) ? 17'($urandom_range(0, 300)) : 17'd0);
      write_reg(CFG_ACCEL_DB, (ph == 3) ? 17'($urandom) : 17'($urandom_range(0, 40)));
      for (int i = 0; i < 205; i++) send_sample(rnd_sample());
    end
    drain();
    stim_done = 1'b1;

    $display("Covered %0d words (%0d clears) and %0d results over alpha, gyro and",
             words_in, clears_sent, results_seen);
    $display("accel deadband settings from zero to full scale.");
    if (errors == 0 && pending_att.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
